// ===== src/kme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kme_pkg;

  localparam int ROW_W  = 4;
  localparam int COLB_W = 8;
  localparam int CODE_W = 7;
  localparam int PEND_W = 2 * COLB_W;
  localparam int PIDX_W = $clog2(PEND_W);

  localparam logic [COLB_W-1:0] RESET_LEVELS = 8'hFF;

  localparam logic OP_SCAN   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam logic DIR_PRESS   = 1'b0;
  localparam logic DIR_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KME_IDLE,
    KME_CALC,
    KME_EMIT
  } kme_state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic skip;
    logic preset;
    logic chg_any;
    logic pend_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/kme_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kme_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [kme_pkg::ROW_W-1:0]   row;
  logic [kme_pkg::COLB_W-1:0]  column_bits;

  modport source (output valid, output op, output row, output column_bits, input ready);
  modport sink   (input valid, input op, input row, input column_bits, output ready);
endinterface

`default_nettype wire

// ===== src/kme_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kme_out_if;
  logic                        valid;
  logic                        ready;
  logic [kme_pkg::CODE_W-1:0]  key_code;
  logic                        is_system;
  logic                        direction;
  logic                        last;

  modport source (output valid, output key_code, output is_system, output direction,
                  output last, input ready);
  modport sink   (input valid, input key_code, input is_system, input direction,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== src/kme_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kme_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kme_pkg::dp_sts_t  sts,
  output kme_pkg::ctl_cmd_t      cmd
);

  kme_pkg::kme_state_t state_r;
  kme_pkg::kme_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kme_pkg::KME_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kme_pkg::KME_IDLE: begin
        if (in_valid) begin
          state_nxt = kme_pkg::KME_CALC;
        end
      end
      kme_pkg::KME_CALC: begin
        if (sts.skip || sts.preset || !sts.chg_any) begin
          state_nxt = kme_pkg::KME_IDLE;
        end else begin
          state_nxt = kme_pkg::KME_EMIT;
        end
      end
      kme_pkg::KME_EMIT: begin
        if (sts.out_free && sts.pend_last) begin
          state_nxt = kme_pkg::KME_IDLE;
        end
      end
      default: begin
        state_nxt = kme_pkg::KME_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      kme_pkg::KME_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      kme_pkg::KME_CALC: begin
        cmd.calc = !sts.skip;
      end
      kme_pkg::KME_EMIT: begin
        cmd.step = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/kme_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kme_datapath #(
  parameter int ROWS = 10,
  parameter int COLS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kme_pkg::ctl_cmd_t           cmd,
  output kme_pkg::dp_sts_t                 sts,
  input  wire logic                        in_op,
  input  wire logic [kme_pkg::ROW_W-1:0]   in_row,
  input  wire logic [kme_pkg::COLB_W-1:0]  in_column_bits,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kme_pkg::CODE_W-1:0]       out_key_code,
  output logic                             out_is_system,
  output logic                             out_direction,
  output logic                             out_last
);

  localparam int DEPTH  = ROWS + 1;
  localparam int IDXW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EVC    = (COLS < kme_pkg::COLB_W) ? COLS : kme_pkg::COLB_W;
  localparam int PROD_W = kme_pkg::ROW_W + 5;
  localparam logic [kme_pkg::COLB_W-1:0] COL_MASK =
    kme_pkg::COLB_W'((16'(1) << EVC) - 16'(1));

  logic [kme_pkg::COLB_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]           valid_r;

  logic [kme_pkg::COLB_W-1:0] rd_data_r;
  logic                       rd_valid_r;
  logic                       op_r;
  logic                       skip_r;
  logic                       sys_r;
  logic [kme_pkg::ROW_W-1:0]  row_r;
  logic [IDXW-1:0]            idx_r;
  logic [kme_pkg::COLB_W-1:0] now_r;
  logic [PROD_W-1:0]          base_r;
  logic [kme_pkg::PEND_W-1:0] pend_r;

  logic                       out_valid_r;
  logic [kme_pkg::CODE_W-1:0] key_code_r;
  logic                       is_system_r;
  logic                       direction_r;
  logic                       last_r;

  logic                       in_range;
  logic [IDXW-1:0]            in_idx;
  logic [kme_pkg::COLB_W-1:0] prior;
  logic [kme_pkg::COLB_W-1:0] pressed;
  logic [kme_pkg::COLB_W-1:0] released;
  logic [kme_pkg::PEND_W-1:0] lowbit;
  logic [kme_pkg::PEND_W-1:0] pend_rest;
  logic [kme_pkg::PIDX_W-1:0] low_idx;
  logic [PROD_W-1:0]          prod;
  logic                       out_free;

  assign in_range = (32'(in_row) <= 32'(ROWS));
  assign in_idx   = IDXW'(in_row);

  assign prior    = rd_valid_r ? rd_data_r : kme_pkg::RESET_LEVELS;
  assign pressed  = ~now_r & prior & COL_MASK;
  assign released = now_r & ~prior & COL_MASK;
  assign prod     = PROD_W'(row_r) * PROD_W'(COLS);

  assign lowbit    = pend_r & (~pend_r + kme_pkg::PEND_W'(1));
  assign pend_rest = pend_r & ~lowbit;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < kme_pkg::PEND_W; i++) begin
      if (lowbit[i]) begin
        low_idx = low_idx | kme_pkg::PIDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      rd_data_r <= mem_r[in_idx];
    end
    if (cmd.calc) begin
      mem_r[idx_r] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      skip_r     <= 1'b1;
      op_r       <= kme_pkg::OP_SCAN;
      pend_r     <= '0;
    end else begin
      if (cmd.load) begin
        skip_r     <= !in_range;
        op_r       <= in_op;
        rd_valid_r <= in_range && valid_r[in_idx];
      end
      if (cmd.calc) begin
        valid_r[idx_r] <= 1'b1;
        pend_r         <= {released, pressed};
      end else if (cmd.step) begin
        pend_r <= pend_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_row;
      idx_r <= in_idx;
      now_r <= in_column_bits;
      sys_r <= (32'(in_row) == 32'(ROWS));
    end
    if (cmd.calc) begin
      base_r <= sys_r ? '0 : prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      key_code_r  <= kme_pkg::CODE_W'(base_r + PROD_W'(low_idx[kme_pkg::PIDX_W-2:0]));
      is_system_r <= sys_r;
      direction_r <= low_idx[kme_pkg::PIDX_W-1] ? kme_pkg::DIR_RELEASE : kme_pkg::DIR_PRESS;
      last_r      <= (pend_rest == '0);
    end
  end

  assign sts.skip      = skip_r;
  assign sts.preset    = (op_r == kme_pkg::OP_PRESET);
  assign sts.chg_any   = |{released, pressed};
  assign sts.pend_last = (pend_rest == '0);
  assign sts.out_free  = out_free;

  assign out_valid     = out_valid_r;
  assign out_key_code  = key_code_r;
  assign out_is_system = is_system_r;
  assign out_direction = direction_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// ===== src/key_matrix_event_generator.sv =====
// Key matrix event generator.
// in_ch takes one row item per transfer: op (scan or preset), row index and
// the active-low column levels of that row. Row ROWS is the system button row;
// higher row indexes are dropped with no effect.
// out_ch gives one event per changed column: press events first, then release
// events, each in ascending column order; last marks the final event of a scan.
// An input transfer loads the item registers and reads the row store through
// a registered port, once per item; the CALC state fills a pending-change
// vector and the EMIT state moves the first event into the output register.
// The event loop emits one column per cycle while the output register is free.
// Preset items and scans with no change give no event.
// At reset every row reads as all keys released; per-row valid bits clear at
// once, so no clearing pass is needed and the first item is taken right away.
// When the receiver stalls, the pending event holds in the output register and
// the event loop waits; input is taken again only after the last event of the
// current scan has entered the output register.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_event_generator #(
  parameter int ROWS = 10,
  parameter int COLS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kme_in_if.sink     in_ch,
  kme_out_if.source  out_ch
);

  kme_pkg::ctl_cmd_t cmd;
  kme_pkg::dp_sts_t  sts;
  logic              in_ready;

  kme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kme_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_ch.op),
    .in_row         (in_ch.row),
    .in_column_bits (in_ch.column_bits),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_key_code   (out_ch.key_code),
    .out_is_system  (out_ch.is_system),
    .out_direction  (out_ch.direction),
    .out_last       (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again right after a transfer");

  a_scan_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> !in_ch.ready)
    else $error("input ready while a scan still has events");

  a_system_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_system |-> (out_ch.key_code < 7'd8))
    else $error("system event with key code beyond column range");

endmodule

`default_nettype wire

// ===== tb/sv/key_matrix_event_generator_test.sv =====
`timescale 1ns / 1ps

module key_matrix_event_generator_test;

  localparam int ROWS = 10;
  localparam int COLS = 8;
  localparam int EVENT_COLS = (COLS < kme_pkg::COLB_W) ? COLS : kme_pkg::COLB_W;

  typedef struct packed {
    logic                       op;
    logic [kme_pkg::ROW_W-1:0]  row;
    logic [kme_pkg::COLB_W-1:0] levels;
  } row_item_t;

  typedef struct packed {
    logic [kme_pkg::CODE_W-1:0] code;
    logic                       sys;
    logic                       dir;
    logic                       last;
  } key_event_t;

  logic clk;
  logic rst_n;

  kme_in_if  in_ch ();
  kme_out_if out_ch ();

  key_matrix_event_generator #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  row_item_t                  pending_rows[$];
  key_event_t                 expected_events[$];
  logic [kme_pkg::COLB_W-1:0] key_levels[0:ROWS];
  int                         errors = 0;

  row_item_t cur_row;
  bit        in_busy = 0;
  bit        in_taken = 0;
  bit        in_calm = 0;
  int        in_gap = 0;
  bit        out_taken = 0;
  bit        out_calm = 0;
  int        out_stall = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void predict_events(row_item_t it);
    logic [kme_pkg::COLB_W-1:0] prior;
    logic [kme_pkg::COLB_W-1:0] mask;
    key_event_t                 ev;
    int                         total;
    int                         n;
    int                         code_full;
    if (it.row > ROWS) return;
    if (it.op == kme_pkg::OP_PRESET) begin
      key_levels[it.row] = it.levels;
      return;
    end
    prior = key_levels[it.row];
    total = 0;
    for (int c = 0; c < EVENT_COLS; c++) begin
      if (prior[c] != it.levels[c]) total++;
    end
    n = 0;
    for (int d = 0; d < 2; d++) begin
      mask = (d == 0) ? (~it.levels & prior) : (it.levels & ~prior);
      for (int c = 0; c < EVENT_COLS; c++) begin
        if (mask[c]) begin
          n++;
          code_full = (it.row == ROWS) ? c : it.row * COLS + c;
          ev.code = code_full[kme_pkg::CODE_W-1:0];
          ev.sys  = (it.row == ROWS);
          ev.dir  = (d == 0) ? kme_pkg::DIR_PRESS : kme_pkg::DIR_RELEASE;
          ev.last = (n == total);
          expected_events.push_back(ev);
        end
      end
    end
    key_levels[it.row] = it.levels;
  endfunction

  function automatic void queue_row(logic op, int row, logic [kme_pkg::COLB_W-1:0] levels);
    row_item_t it;
    it.op = op;
    it.row = row[kme_pkg::ROW_W-1:0];
    it.levels = levels;
    pending_rows.push_back(it);
  endfunction

  // sender
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_events(row_item_t'{in_ch.op, in_ch.row, in_ch.column_bits});
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_busy || in_taken) begin
        if (in_busy) begin
          in_busy = 0;
          in_gap = in_calm ? 0 : int'($urandom_range(0, 19));
          if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
        end
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          cur_row = pending_rows.pop_front();
          in_ch.op          <= cur_row.op;
          in_ch.row         <= cur_row.row;
          in_ch.column_bits <= cur_row.levels;
          in_ch.valid       <= 1'b1;
          in_busy = 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_stall = out_calm ? 0 : int'($urandom_range(0, 19));
        if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    key_event_t want;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event: expected none, actual %0d/%0b/%0b/%0b",
                 $time, out_ch.key_code, out_ch.is_system, out_ch.direction, out_ch.last);
      end else begin
        want = expected_events.pop_front();
        if (out_ch.key_code !== want.code || out_ch.is_system !== want.sys ||
            out_ch.direction !== want.dir || out_ch.last !== want.last) begin
          errors++;
          $display("%0t: event mismatch: expected %0d/%0b/%0b/%0b, actual %0d/%0b/%0b/%0b",
                   $time, want.code, want.sys, want.dir, want.last,
                   out_ch.key_code, out_ch.is_system, out_ch.direction, out_ch.last);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [kme_pkg::COLB_W-1:0] shadow[0:ROWS];
    row_item_t                  it;
    int                         pick;
    int                         counted;

    in_ch.valid       = 1'b0;
    in_ch.op          = kme_pkg::OP_SCAN;
    in_ch.row         = '0;
    in_ch.column_bits = '0;
    out_ch.ready      = 1'b0;
    for (int r = 0; r <= ROWS; r++) key_levels[r] = kme_pkg::RESET_LEVELS;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    queue_row(kme_pkg::OP_SCAN, 0, 8'h00);
    queue_row(kme_pkg::OP_SCAN, 0, 8'hFF);
    queue_row(kme_pkg::OP_SCAN, 9, 8'h7F);
    queue_row(kme_pkg::OP_SCAN, 9, 8'hFF);
    queue_row(kme_pkg::OP_SCAN, ROWS, 8'hFE);
    queue_row(kme_pkg::OP_SCAN, ROWS, 8'hFD);
    queue_row(kme_pkg::OP_SCAN, ROWS, 8'hFF);
    queue_row(kme_pkg::OP_SCAN, 11, 8'h00);
    queue_row(kme_pkg::OP_PRESET, 15, 8'h00);
    queue_row(kme_pkg::OP_SCAN, 15, 8'h00);
    queue_row(kme_pkg::OP_SCAN, 0, 8'hFF);
    queue_row(kme_pkg::OP_PRESET, 3, 8'h00);
    queue_row(kme_pkg::OP_SCAN, 3, 8'h00);
    queue_row(kme_pkg::OP_SCAN, 3, 8'hA5);
    queue_row(kme_pkg::OP_SCAN, 5, 8'h5A);
    queue_row(kme_pkg::OP_SCAN, 5, 8'hA5);
    queue_row(kme_pkg::OP_PRESET, ROWS, 8'h0F);
    queue_row(kme_pkg::OP_SCAN, ROWS, 8'hF0);
    queue_row(kme_pkg::OP_SCAN, 7, 8'hEF);
    queue_row(kme_pkg::OP_PRESET, 7, 8'hFF);
    queue_row(kme_pkg::OP_SCAN, 7, 8'hFF);
    queue_row(kme_pkg::OP_SCAN, 1, 8'h80);
    queue_row(kme_pkg::OP_SCAN, 1, 8'h01);

    // hold off until the directed events have drained
    while (pending_rows.size() > 0 || in_busy) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);

    for (int r = 0; r <= ROWS; r++) shadow[r] = key_levels[r];
    counted = 0;
    while (counted < 140) begin
      pick = $urandom_range(0, 99);
      it.row = kme_pkg::ROW_W'($urandom_range(0, ROWS));
      it.op = kme_pkg::OP_SCAN;
      if (pick < 55) begin
        it.levels = shadow[it.row] ^ (8'h01 << $urandom_range(0, 7));
        if ($urandom_range(0, 1)) it.levels ^= 8'h01 << $urandom_range(0, 7);
      end else if (pick < 75) begin
        it.levels = kme_pkg::COLB_W'($urandom);
      end else if (pick < 83) begin
        it.levels = shadow[it.row];
      end else if (pick < 93) begin
        it.op = kme_pkg::OP_PRESET;
        it.levels = kme_pkg::COLB_W'($urandom);
      end else begin
        it.row = kme_pkg::ROW_W'($urandom_range(ROWS + 1, 15));
        it.op = $urandom_range(0, 1) ? kme_pkg::OP_PRESET : kme_pkg::OP_SCAN;
        it.levels = kme_pkg::COLB_W'($urandom);
      end
      if (it.row <= ROWS) begin
        shadow[it.row] = it.levels;
        counted++;
      end
      pending_rows.push_back(it);
    end

    while (pending_rows.size() > 0 || in_busy) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
